FILE: design/hash_set_insert_and_member_unit_macros.svh
// Assertion macros for the hash set unit.
`ifndef HASH_SET_INSERT_AND_MEMBER_UNIT_MACROS_SVH
`define HASH_SET_INSERT_AND_MEMBER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HSIM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
`define HSIM_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`else
`define HSIM_ASSERT(label, prop)
`define HSIM_ASSERT_MSG(label, prop, msg)
`endif

`endif

FILE: design/hsim_pkg.sv
// Types and constants shared by the hash set unit.
package hsim_pkg;

	localparam int SLOT_BITS = 16;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int KEY_W = 64;
	localparam logic [KEY_W-1:0] EMPTY_MARK = '1;
	localparam logic [KEY_W-1:0] MULT_RESET = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [SLOT_BITS-1:0] HALF_SLOTS = SLOT_BITS'(SLOT_COUNT / 2);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam logic [2:0] ST_PRESENT = 3'd0;
	localparam logic [2:0] ST_ADDED = 3'd1;
	localparam logic [2:0] ST_ABSENT = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic opcode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] entry_count;
	} rsp_t;

	// classified item handed from front to back
	typedef struct packed {
		logic opcode;
		logic invalid;
		logic [KEY_W-1:0] key;
		logic [SLOT_BITS-1:0] home;
	} task_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_RESULT
	} back_state_t;

endpackage

FILE: design/hsim_ram.sv
// Generic simple dual-port RAM with registered read.
module hsim_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: design/hsim_queue.sv
// Two-entry queue of classified items between front and back.
module hsim_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hsim_pkg::task_t wr_task,
	input  logic            pop,
	output hsim_pkg::task_t head,
	output hsim_pkg::q_stat_t stat
);
	import hsim_pkg::*;

	task_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign stat.full = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wr_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: design/hsim_front.sv
// Front end: accepts items, hashes the key and classifies it.
module hsim_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hsim_pkg::req_t    request,
	output logic              full,
	input  logic              clearing,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_data,
	output logic              q_push,
	output hsim_pkg::task_t   q_task,
	input  hsim_pkg::q_stat_t q_stat
);
	import hsim_pkg::*;

	logic [KEY_W-1:0] mult_q;
	logic en;
	logic acc;

	logic v_s1;
	req_t req_s1;

	logic v_s2;
	logic opcode_s2;
	logic invalid_s2;
	logic [KEY_W-1:0] key_s2;
	logic [63:0] p_ll_s2;
	logic [31:0] p_lh_s2;
	logic [31:0] p_hl_s2;

	logic v_s3;
	task_t task_s3;

	logic [63:0] prod_ll;
	logic [63:0] prod_lh;
	logic [63:0] prod_hl;
	logic [63:0] hash;

	// stall the whole pipe only when the last stage cannot hand off
	assign en = !v_s3 || !q_stat.full;
	assign full = clearing || !en;
	assign acc = push && !full;
	assign q_push = v_s3 && !q_stat.full;
	assign q_task = task_s3;

	// low 64 bits of key * mult from three 32x32 products
	assign prod_ll = req_s1.key[31:0] * mult_q[31:0];
	assign prod_lh = req_s1.key[31:0] * mult_q[63:32];
	assign prod_hl = req_s1.key[63:32] * mult_q[31:0];
	assign hash = p_ll_s2 + {p_lh_s2 + p_hl_s2, 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= MULT_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg_we) begin
				mult_q <= cfg_data;
			end
			if (en) begin
				v_s1 <= acc;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= request;
			opcode_s2 <= req_s1.opcode;
			invalid_s2 <= (req_s1.key == EMPTY_MARK);
			key_s2 <= req_s1.key;
			p_ll_s2 <= prod_ll;
			p_lh_s2 <= prod_lh[31:0];
			p_hl_s2 <= prod_hl[31:0];
			task_s3.opcode <= opcode_s2;
			task_s3.invalid <= invalid_s2;
			task_s3.key <= key_s2;
			task_s3.home <= hash[63 -: SLOT_BITS];
		end
	end
endmodule

FILE: design/hsim_back.sv
// Back end: clears the table, probes it and stores keys, holds the result.
module hsim_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hsim_pkg::task_t   head,
	input  hsim_pkg::q_stat_t q_stat,
	output logic              q_pop,
	output logic              clearing,
	output logic              empty,
	input  logic              pop,
	output hsim_pkg::rsp_t    response
);
	import hsim_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic [SLOT_BITS-1:0] clr_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] steps_q;
	logic [SLOT_BITS-1:0] count_q;
	task_t cur_q;
	logic [2:0] status_q;
	logic res_valid_q;
	rsp_t res_q;

	logic ram_we;
	logic [SLOT_BITS-1:0] ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic ram_re;
	logic [KEY_W-1:0] ram_rdata;

	logic hit;
	logic empty_hit;
	logic at_limit;
	logic res_load;

	hsim_ram #(
		.WIDTH(KEY_W),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	assign hit = (ram_rdata == cur_q.key);
	assign empty_hit = (ram_rdata == EMPTY_MARK);
	assign at_limit = (count_q >= HALF_SLOTS);
	assign clearing = (state_q == BK_CLEAR);
	assign empty = !res_valid_q;
	assign response = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = cur_q.key;
		ram_re = 1'b0;
		q_pop = 1'b0;
		res_load = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = EMPTY_MARK;
				if (clr_q == '1) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					state_d = head.invalid ? BK_RESULT : BK_READ;
				end
			end
			BK_READ: begin
				ram_re = 1'b1;
				state_d = BK_CHECK;
			end
			BK_CHECK: begin
				if (hit || empty_hit || steps_q == '1) begin
					state_d = BK_RESULT;
				end else begin
					state_d = BK_READ;
				end
				if (!hit && empty_hit && cur_q.opcode == OP_INSERT && !at_limit) begin
					ram_we = 1'b1;
				end
			end
			BK_RESULT: begin
				if (!res_valid_q || pop) begin
					res_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ram_we && state_q == BK_CHECK) begin
				count_q <= count_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
			slot_q <= head.home;
			steps_q <= '0;
			// only used when the key is the empty mark
			status_q <= (head.opcode == OP_TEST) ? ST_ABSENT : ST_INVALID;
		end
		if (state_q == BK_CHECK) begin
			if (hit) begin
				status_q <= ST_PRESENT;
			end else if (empty_hit) begin
				if (cur_q.opcode == OP_TEST) begin
					status_q <= ST_ABSENT;
				end else begin
					status_q <= at_limit ? ST_FULL : ST_ADDED;
				end
			end else begin
				slot_q <= slot_q + 1'b1;
				steps_q <= steps_q + 1'b1;
				// wrapped all the way round without a match or a hole
				status_q <= (cur_q.opcode == OP_TEST) ? ST_ABSENT : ST_FULL;
			end
		end
		if (res_load) begin
			res_q.status <= status_q;
			res_q.entry_count <= 16'(count_q);
		end
	end
endmodule

FILE: design/hash_set_insert_and_member_unit.sv
// Hash set of 64-bit keys with linear probing: top level.
//
// Requests enter through a queue-style port: an item is taken when push is
// high and full is low. Opcode insert adds the key, opcode test looks it up.
// Results leave the same way: while empty is low the oldest result is on
// response and it is taken when pop is high. Each request yields one result.
// cfg_we with cfg_data loads the hash multiplier; write it only while idle.
// A three-stage front computes the home slot (split 64-bit multiply), then a
// two-entry queue feeds the back end, which probes a simple dual-port table
// RAM with registered read. The back end takes one item at a time: it pops
// it, then reads and checks one slot per probe step until a match, an empty slot
// or a full wrap, then loads the result; an empty-mark key is not probed.
// After reset the table is swept to empty, one slot a cycle, across all
// 65536 slots; full stays high during that pass. If the receiver stalls, the
// result register holds, the back end waits after its next item and the
// front keeps taking items until its queue and stages fill.
module hash_set_insert_and_member_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hsim_pkg::req_t request,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output hsim_pkg::rsp_t response,
	input  logic           cfg_we,
	input  logic [63:0]    cfg_data
);
	import hsim_pkg::*;

	`include "hash_set_insert_and_member_unit_macros.svh"

	logic clearing;
	logic q_push;
	logic q_pop;
	task_t q_task;
	task_t q_head;
	q_stat_t q_stat;

	hsim_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.request (request),
		.full    (full),
		.clearing(clearing),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.q_push  (q_push),
		.q_task  (q_task),
		.q_stat  (q_stat)
	);

	hsim_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_task(q_task),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	hsim_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.clearing(clearing),
		.empty   (empty),
		.pop     (pop),
		.response(response)
	);

	`HSIM_ASSERT_MSG(a_no_push_when_full, q_push |-> !q_stat.full, "front pushed into full queue")
	`HSIM_ASSERT_MSG(a_no_pop_when_empty, q_pop |-> !q_stat.empty, "back popped empty queue")
	`HSIM_ASSERT(a_clear_once, !clearing |=> !clearing)
	`HSIM_ASSERT(a_no_work_while_clearing, clearing |-> !q_pop && empty)
endmodule
